// ===== src/sha256_pkg.sv =====
// Package: SHA-256 types, constants and round functions.
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic       load_byte;
		logic [7:0] byte_val;
		logic       pad_start;
		logic       pad_zero_all;
		logic       put_length;
		logic       round_start;
		logic       round_step;
		logic       round_finish;
		logic       reset_chain;
	} dp_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic       pos_ge_56;
		logic       rounds_last;
	} dp_status_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int k);
		return (v >> k) | (v << (32 - k));
	endfunction

endpackage

// ===== src/sha256_datapath.sv =====
// Datapath: block buffer, message schedule, round logic and chaining state.
module sha256_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256_pkg::dp_cmd_t     cmd,
	output sha256_pkg::dp_status_t  status,
	input  logic [2:0]              rd_index,
	output logic [31:0]             rd_word
);

	logic [5:0]  fill_q;
	logic [60:0] msg_q;
	logic [31:0] h_q [8];
	logic [31:0] r_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [63:0] bits;
	logic [31:0] s0, s1, wnew, big1, big0, ch, maj, x1;

	assign bits = {msg_q, 3'b000};
	assign status.block_full = (fill_q == 6'd0) && cmd.load_byte == 1'b0;
	assign status.pos_ge_56 = fill_q >= sha256_pkg::LEN_POS;
	assign status.rounds_last = rnd_q == 6'd63;
	assign rd_word = h_q[rd_index];

	always_comb begin
		s0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		big1 = sha256_pkg::rotr(r_q[4], 6) ^ sha256_pkg::rotr(r_q[4], 11)
			^ sha256_pkg::rotr(r_q[4], 25);
		ch = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
		x1 = r_q[7] + big1 + ch + sha256_pkg::ROUND_K[rnd_q] + w_q[0];
		big0 = sha256_pkg::rotr(r_q[0], 2) ^ sha256_pkg::rotr(r_q[0], 13)
			^ sha256_pkg::rotr(r_q[0], 22);
		maj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
	end

	// the schedule words hold the block bytes big-endian until the rounds start
	always_ff @(posedge clk) begin
		if (cmd.round_start) begin
			for (int t = 0; t < 8; t++) r_q[t] <= h_q[t];
		end else if (cmd.round_step) begin
			for (int t = 0; t < 15; t++) w_q[t] <= w_q[t+1];
			w_q[15] <= wnew;
			r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + x1;
			r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
			r_q[0] <= x1 + big0 + maj;
		end else if (cmd.load_byte) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= cmd.byte_val;
		end else if (cmd.pad_start) begin
			for (int t = 0; t < 16; t++) begin
				for (int b = 0; b < 4; b++) begin
					if (6'(4*t + b) == fill_q)
						w_q[t][8*(3-b) +: 8] <= sha256_pkg::PAD_BYTE;
					else if (6'(4*t + b) > fill_q)
						w_q[t][8*(3-b) +: 8] <= 8'h00;
				end
			end
		end else if (cmd.pad_zero_all) begin
			for (int t = 0; t < 16; t++) w_q[t] <= '0;
		end else if (cmd.put_length) begin
			w_q[14] <= bits[63:32];
			w_q[15] <= bits[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			msg_q <= '0;
			rnd_q <= '0;
			for (int t = 0; t < 8; t++) h_q[t] <= sha256_pkg::H_INIT[t];
		end else begin
			if (cmd.load_byte) begin
				fill_q <= fill_q + 6'd1;
				msg_q <= msg_q + 61'd1;
			end
			if (cmd.round_start) rnd_q <= '0;
			else if (cmd.round_step) rnd_q <= rnd_q + 6'd1;
			if (cmd.round_finish) begin
				for (int t = 0; t < 8; t++) h_q[t] <= h_q[t] + r_q[t];
			end
			if (cmd.reset_chain) begin
				fill_q <= '0;
				msg_q <= '0;
				for (int t = 0; t < 8; t++) h_q[t] <= sha256_pkg::H_INIT[t];
			end
		end
	end

endmodule

// ===== src/sha256_ctrl.sv =====
// Controller: sequences byte loads, padding, compressions and digest output.
module sha256_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  sha256_pkg::in_item_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              out_index,
	output sha256_pkg::dp_cmd_t     cmd,
	input  sha256_pkg::dp_status_t  status
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_START = 8'b0000_0100,
		ST_ROUND = 8'b0000_1000,
		ST_DONE  = 8'b0001_0000,
		ST_PAD   = 8'b0010_0000,
		ST_LEN   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic end_q, end_d;
	logic final_q, final_d;
	logic [2:0] idx_q, idx_d;
	logic loaded_q;

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign out_index = idx_q;

	always_comb begin
		state_d = state_q;
		end_d = end_q;
		final_d = final_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.byte_val = in_data.data_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_byte = in_data.has_byte;
					end_d = in_data.end_of_message;
					final_d = 1'b0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.block_full && !final_q && loaded_q) state_d = ST_START;
				else if (end_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: begin
				cmd.pad_start = 1'b1;
				if (status.pos_ge_56) begin
					final_d = 1'b0;
					state_d = ST_START;
					end_d = 1'b1;
					idx_d = 3'd1;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.put_length = 1'b1;
				final_d = 1'b1;
				state_d = ST_START;
			end
			ST_START: begin
				cmd.round_start = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (status.rounds_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.round_finish = 1'b1;
				if (final_q) begin
					idx_d = 3'd0;
					state_d = ST_OUT;
				end else if (end_q && idx_q == 3'd1) begin
					cmd.pad_zero_all = 1'b1;
					idx_d = 3'd0;
					state_d = ST_LEN;
				end else if (end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_chain = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q <= 1'b0;
			final_q <= 1'b0;
			idx_q <= '0;
			loaded_q <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q <= end_d;
			final_q <= final_d;
			idx_q <= idx_d;
			if (state_q == ST_IDLE) loaded_q <= in_valid && in_data.has_byte;
			else if (state_q == ST_CHECK) loaded_q <= 1'b0;
		end
	end

endmodule

// ===== src/sha256_message_digest_top.sv =====
// Top level: SHA-256 digest of a byte stream, one byte per item.
// An item visits the idle and check states; each 64th byte adds a compression
// (one round per cycle in the shared round unit). An ending item adds padding
// and one or two compressions, then the eight digest words leave one per
// cycle while out_ready is high. The next item is taken after word 7 leaves.
module sha256_message_digest_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sha256_pkg::in_item_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sha256_pkg::out_item_t  out_data
);

	sha256_pkg::dp_cmd_t    cmd;
	sha256_pkg::dp_status_t status;
	logic [2:0]  idx;
	logic [31:0] word;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_index(idx), .cmd, .status
	);

	sha256_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .rd_index(idx), .rd_word(word)
	);

	assign out_data.digest_word = word;
	assign out_data.word_index = idx;
	assign out_data.last_word = idx == 3'd7;

endmodule

// ===== src/sha256_checker.sv =====
// Checker: port-level properties of the digest block, bound to the top level.
module sha256_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input sha256_pkg::out_item_t out_data
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken during output");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last_word mismatch");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.word_index != 3'd7) |=>
		(out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
		else $error("word index skipped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output changed while stalled");

endmodule

bind sha256_message_digest_top sha256_checker u_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
